@@ rtl/core/div64_pkg.sv @@
package div64_pkg;

   localparam int WORD_WIDTH = 64;

   typedef struct packed {
      logic                  action;
      logic [WORD_WIDTH-1:0] dividend;
      logic [WORD_WIDTH-1:0] divisor;
   } div64_req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] quotient;
      logic [WORD_WIDTH-1:0] remainder;
      logic                  divide_by_zero;
   } div64_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } div64_cmd_type;

endpackage

@@ rtl/core/div64_ctrl.sv @@
module div64_ctrl #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output div64_pkg::div64_cmd_type cmd
);

   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIX} state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 stall_ff, stall_in;
   logic                 valid_ff, valid_in;
   logic                 out_free;

   assign req_stall = stall_ff;
   assign rsp_valid = valid_ff;
   assign out_free  = !valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_WIDTH'(DATA_WIDTH - 1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
      if (cmd.finish) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         stall_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stall_ff <= stall_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ rtl/core/div64_datapath.sv @@
module div64_datapath #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                     clock,
   input  div64_pkg::div64_req_type req_data,
   input  div64_pkg::div64_cmd_type cmd,
   output div64_pkg::div64_rsp_type rsp_data
);

   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic                  qneg_ff, qneg_in;
   logic                  rneg_ff, rneg_in;
   logic                  zero_ff, zero_in;

   logic [DATA_WIDTH-1:0] num;
   logic [DATA_WIDTH-1:0] den;
   logic                  num_neg;
   logic                  den_neg;
   logic [DATA_WIDTH:0]   partial;
   logic [DATA_WIDTH+1:0] diff;
   logic [DATA_WIDTH-1:0] quo_fix;
   logic [DATA_WIDTH-1:0] rem_fix;

   div64_pkg::div64_rsp_type rsp_ff;

   assign rsp_data = rsp_ff;

   always_comb begin
      num     = req_data.dividend[DATA_WIDTH-1:0];
      den     = req_data.divisor[DATA_WIDTH-1:0];
      num_neg = req_data.action && num[DATA_WIDTH-1];
      den_neg = req_data.action && den[DATA_WIDTH-1];
      partial = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = {1'b0, partial} - {2'b00, den_ff};
      quo_fix = qneg_ff ? ({DATA_WIDTH{1'b0}} - quo_ff) : quo_ff;
      rem_fix = rneg_ff ? ({DATA_WIDTH{1'b0}} - rem_ff) : rem_ff;

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      zero_in = zero_ff;
      if (cmd.load) begin
         quo_in  = num_neg ? ({DATA_WIDTH{1'b0}} - num) : num;
         den_in  = den_neg ? ({DATA_WIDTH{1'b0}} - den) : den;
         rem_in  = '0;
         qneg_in = num_neg ^ den_neg;
         rneg_in = num_neg;
         zero_in = (den == '0);
      end else if (cmd.step) begin
         if (diff[DATA_WIDTH+1]) begin
            rem_in = partial[DATA_WIDTH-1:0];
         end else begin
            rem_in = diff[DATA_WIDTH-1:0];
         end
         quo_in = {quo_ff[DATA_WIDTH-2:0], !diff[DATA_WIDTH+1]};
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      zero_ff <= zero_in;
      if (cmd.finish) begin
         rsp_ff.divide_by_zero <= zero_ff;
         if (zero_ff) begin
            rsp_ff.quotient  <= '0;
            rsp_ff.remainder <= '0;
         end else begin
            rsp_ff.quotient  <= div64_pkg::WORD_WIDTH'(quo_fix);
            rsp_ff.remainder <= div64_pkg::WORD_WIDTH'(rem_fix);
         end
      end
   end

endmodule

@@ rtl/core/divider_64bit_signed_unsigned_core.sv @@
// The restoring subtract loop yields one quotient bit per cycle; the core takes one request at a time.
// Operand magnitudes are loaded at the accepting edge; after the loop, signs are applied as the result is registered.
// Reset is synchronous and active high; it clears the controller only, not the datapath.
module divider_64bit_signed_unsigned_core #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  div64_pkg::div64_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output div64_pkg::div64_rsp_type rsp_data
);

   div64_pkg::div64_cmd_type cmd;

   div64_ctrl #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd)
   );

   div64_datapath #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_datapath (
      .clock   (clock),
      .req_data(req_data),
      .cmd     (cmd),
      .rsp_data(rsp_data)
   );

endmodule

@@ rtl/core/div64_checker.sv @@
module div64_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input div64_pkg::div64_rsp_type rsp_data
);

   // A stalled result stays valid and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The block takes one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // A new result only appears at the end of a division in progress.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a request in progress");

   // A zero divisor gives zero quotient and remainder.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         rsp_data.quotient == '0 && rsp_data.remainder == '0)
      else $error("nonzero result on divide by zero");

endmodule

bind divider_64bit_signed_unsigned_core div64_checker u_checker (.*);
